/* rtl/assert_macros.svh */
// Assertion macros used by the checker file, sstenc_checker.
// Each macro expects clk_i and rst_ni in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/sstenc_pkg.sv */
// Seven-segment text encoder: shared types, constants, glyph tables and helpers.
// No dependencies.
package sstenc_pkg;

  localparam int unsigned Digits = 4;
  localparam int unsigned PosW   = 10;

  localparam logic signed [PosW-1:0] PosMax = 10'sh1FF;
  localparam logic signed [PosW-1:0] PosMin = 10'sh200;

  localparam logic [7:0] DotBit    = 8'h80;
  localparam logic [7:0] FlatGlyph = 8'h9F;

  localparam logic [7:0] CharDot        = 8'h2E;
  localparam logic [7:0] CharComma      = 8'h2C;
  localparam logic [7:0] CharMinus      = 8'h2D;
  localparam logic [7:0] CharUnderscore = 8'h5F;
  localparam logic [7:0] CharQuote      = 8'h27;
  localparam logic [7:0] CharBang       = 8'h21;
  localparam logic [7:0] CharCaret      = 8'h5E;
  localparam logic [7:0] CharHash       = 8'h23;
  localparam logic [7:0] CharUpperA     = 8'h41;
  localparam logic [7:0] CharUpperZ     = 8'h5A;
  localparam logic [7:0] CharLowerA     = 8'h61;
  localparam logic [7:0] CharLowerZ     = 8'h7A;
  localparam logic [7:0] CharZero       = 8'h30;
  localparam logic [7:0] CharNine       = 8'h39;

  localparam logic [7:0] NumberGlyphs [10] = '{
    8'h7E, 8'h30, 8'h6D, 8'h79, 8'h33, 8'h5B, 8'h5F, 8'h70, 8'h7F, 8'h7B};

  localparam logic [7:0] UpperGlyphs [26] = '{
    8'h77, 8'h1F, 8'h4E, 8'h3D, 8'h4F, 8'h47, 8'h5E, 8'h37, 8'h04, 8'h38, 8'h57, 8'h0E,
    8'h55, 8'h15, 8'h1D, 8'h67, 8'h73, 8'h05, 8'h5B, 8'h0F, 8'h3E, 8'h27, 8'h5C, 8'h49,
    8'h3B, 8'h6D};

  localparam logic [7:0] LowerGlyphs [26] = '{
    8'h77, 8'h1F, 8'h0D, 8'h3D, 8'h4F, 8'h47, 8'h5E, 8'h37, 8'h04, 8'h38, 8'h57, 8'h0E,
    8'h55, 8'h15, 8'h1D, 8'h67, 8'h73, 8'h05, 8'h5B, 8'h0F, 8'h3E, 8'h27, 8'h5C, 8'h49,
    8'h3B, 8'h6D};

  typedef enum logic [2:0] {
    RegAlignRight   = 3'd0,
    RegScrollOffset = 3'd1,
    RegLowercase    = 3'd2,
    RegDotSelect    = 3'd3,
    RegFlatCode     = 3'd4
  } cfg_reg_e;

  typedef logic [Digits-1:0][7:0] digits_t;

  typedef struct packed {
    digits_t                digits;
    logic signed [PosW-1:0] pos;
    logic                   carry;
    logic [7:0]             prev;
    logic                   stopped;
  } enc_state_t;

  typedef struct packed {
    logic       align_right;
    logic [7:0] scroll_offset;
    logic       lowercase;
    logic [7:0] flat_code;
  } enc_cfg_t;

  function automatic logic signed [PosW-1:0] start_pos(input logic align_right,
                                                        input logic [7:0] scroll);
    logic signed [PosW-1:0] p;
    if (align_right) begin
      p = PosW'(Digits - 1);
    end else begin
      p = -$signed({2'b00, scroll});
    end
    return p;
  endfunction

  function automatic enc_state_t restart_state(input logic align_right,
                                               input logic [7:0] scroll);
    enc_state_t s;
    s.digits  = '0;
    s.pos     = start_pos(align_right, scroll);
    s.carry   = 1'b0;
    s.prev    = 8'h00;
    s.stopped = 1'b0;
    return s;
  endfunction

  function automatic logic [7:0] glyph(input logic [7:0] c, input logic lower,
                                       input logic [7:0] flat);
    logic [7:0] g;
    logic [7:0] ofs;
    g   = 8'h00;
    ofs = 8'h00;
    if (c inside {[CharUpperA:CharUpperZ]}) begin
      ofs = c - CharUpperA;
      g   = UpperGlyphs[ofs[4:0]];
    end else if (c inside {[CharLowerA:CharLowerZ]}) begin
      ofs = c - CharLowerA;
      g   = lower ? LowerGlyphs[ofs[4:0]] : UpperGlyphs[ofs[4:0]];
    end else if (c inside {[CharZero:CharNine]}) begin
      ofs = c - CharZero;
      g   = NumberGlyphs[ofs[3:0]];
    end else begin
      case (c)
        CharMinus:      g = 8'h01;
        CharUnderscore: g = 8'h08;
        CharQuote:      g = 8'h02;
        CharBang:       g = 8'hA0;
        CharCaret:      g = 8'h62;
        CharHash:       g = 8'hA7;
        default:        g = (c == flat) ? FlatGlyph : 8'h00;
      endcase
    end
    return g;
  endfunction

endpackage

/* rtl/sstenc_in_if.sv */
// Input channel of the seven-segment text encoder: one text byte per transaction.
// No dependencies.
interface sstenc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       terminator;

  modport source (output valid, character, terminator, input ready);
  modport sink (input valid, character, terminator, output ready);
endinterface

/* rtl/sstenc_out_if.sv */
// Output channel of the seven-segment text encoder: four digit bytes per transaction.
// No dependencies.
interface sstenc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] digit_zero;
  logic [7:0] digit_one;
  logic [7:0] digit_two;
  logic [7:0] digit_three;

  modport source (output valid, digit_zero, digit_one, digit_two, digit_three, input ready);
  modport sink (input valid, digit_zero, digit_one, digit_two, digit_three, output ready);
endinterface

/* rtl/sstenc_step.sv */
// Next encoder state for one non-terminator character (left or right fill).
// Depends on sstenc_pkg.
module sstenc_step (
  input  sstenc_pkg::enc_state_t st_i,
  input  sstenc_pkg::enc_cfg_t   cfg_i,
  input  logic [7:0]             char_i,
  output sstenc_pkg::enc_state_t st_o
);

  logic [7:0]                         g;
  logic                               is_dot;
  logic signed [sstenc_pkg::PosW-1:0] pos;
  logic signed [sstenc_pkg::PosW-1:0] pm1;
  logic signed [sstenc_pkg::PosW-1:0] pm2;
  logic signed [sstenc_pkg::PosW-1:0] pos_up;
  logic signed [sstenc_pkg::PosW-1:0] pos_dn;
  logic                               pos_ok;
  logic                               pm1_ok;

  assign g      = sstenc_pkg::glyph(char_i, cfg_i.lowercase, cfg_i.flat_code);
  assign is_dot = (char_i == sstenc_pkg::CharDot) || (char_i == sstenc_pkg::CharComma);
  assign pos    = st_i.pos;
  assign pm1    = pos - 10'sd1;
  assign pm2    = pos - 10'sd2;
  assign pos_up = (pos == sstenc_pkg::PosMax) ? pos : pos + 10'sd1;
  assign pos_dn = (pos == sstenc_pkg::PosMin) ? pos : pm1;
  // on a digit when 0 <= p < 4
  assign pos_ok = (pos[sstenc_pkg::PosW-1:2] == '0);
  assign pm1_ok = (pm1[sstenc_pkg::PosW-1:2] == '0);

  always_comb begin
    st_o = st_i;
    if (!cfg_i.align_right) begin
      if (is_dot) begin
        if (pos != sstenc_pkg::start_pos(1'b0, cfg_i.scroll_offset) && !st_i.prev[7]) begin
          // fold into the digit just written
          st_o.prev = st_i.prev | sstenc_pkg::DotBit;
          if (pm1_ok) begin
            st_o.digits[pm1[1:0]] = st_i.prev | sstenc_pkg::DotBit;
          end
        end else begin
          if (pos_ok) begin
            st_o.digits[pos[1:0]] = sstenc_pkg::DotBit;
          end
          st_o.prev = sstenc_pkg::DotBit;
          st_o.pos  = pos_up;
        end
      end else if (char_i == 8'h00 || pos >= 10'sd4) begin
        st_o.stopped = 1'b1;
      end else begin
        if (pos_ok) begin
          st_o.digits[pos[1:0]] = g;
        end
        st_o.prev = g;
        st_o.pos  = pos_up;
      end
    end else begin
      if (is_dot) begin
        if (st_i.carry) begin
          if (pos_ok) begin
            st_o.digits[pos[1:0]] = sstenc_pkg::DotBit;
          end
          st_o.prev = sstenc_pkg::DotBit;
          if (pos == 10'sd0) begin
            st_o.pos     = pm1;
            st_o.stopped = 1'b1;
          end else begin
            st_o.pos = pos_dn;
          end
        end else begin
          st_o.carry = 1'b1;
        end
      end else if (pos < 10'sd0) begin
        st_o.stopped = 1'b1;
      end else if (st_i.carry && g[7]) begin
        // glyph has its own dot: the carried dot takes a digit first
        st_o.digits[pos[1:0]] = sstenc_pkg::DotBit;
        if (pos == 10'sd0) begin
          st_o.pos     = pm1;
          st_o.stopped = 1'b1;
        end else begin
          st_o.digits[pm1[1:0]] = g;
          st_o.carry            = 1'b0;
          st_o.prev             = g;
          st_o.pos              = pm2;
        end
      end else begin
        st_o.digits[pos[1:0]] = st_i.carry ? (g | sstenc_pkg::DotBit) : g;
        st_o.prev             = st_i.carry ? (g | sstenc_pkg::DotBit) : g;
        st_o.carry            = 1'b0;
        st_o.pos              = pos_dn;
      end
    end
  end

endmodule

/* rtl/seven_segment_text_encoder_core.sv */
// Seven-segment text encoder, four digits, one character per transaction. One input
// transaction every cycle unless the output stalls; the next-state logic is a single
// glyph lookup plus position update between the state register and itself. A
// terminator's digits are registered and show on the output in the cycle after it
// is taken. Reset: config registers take their reset values, encoder state restarts,
// output is empty. Depends on sstenc_pkg, sstenc_step, sstenc_in_if, sstenc_out_if.
module seven_segment_text_encoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  sstenc_in_if.sink   in_ch,
  sstenc_out_if.source out_ch
);

  sstenc_pkg::enc_state_t st_q;
  sstenc_pkg::enc_state_t st_step;
  sstenc_pkg::enc_cfg_t   cfg;
  logic                   align_q;
  logic [7:0]             scroll_q;
  logic                   lower_q;
  logic [7:0]             dot_sel_q;
  logic [7:0]             flat_q;
  sstenc_pkg::digits_t    fin;
  sstenc_pkg::digits_t    out_q;
  logic                   out_valid_q;
  logic                   in_acc;

  assign cfg.align_right   = align_q;
  assign cfg.scroll_offset = scroll_q;
  assign cfg.lowercase     = lower_q;
  assign cfg.flat_code     = flat_q;

  assign in_ch.ready = !out_valid_q || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;

  sstenc_step u_step (
    .st_i   (st_q),
    .cfg_i  (cfg),
    .char_i (in_ch.character),
    .st_o   (st_step)
  );

  // blank unused digits, then overlay configured dots
  always_comb begin
    logic signed [sstenc_pkg::PosW-1:0] di;
    fin = st_q.digits;
    for (int i = 0; i < sstenc_pkg::Digits; i++) begin
      di = sstenc_pkg::PosW'(i);
      if (align_q ? (di <= st_q.pos) : (di >= st_q.pos)) begin
        fin[i] = 8'h00;
      end
    end
    if (dot_sel_q < 8'(sstenc_pkg::Digits)) begin
      fin[dot_sel_q[1:0]] = fin[dot_sel_q[1:0]] | sstenc_pkg::DotBit;
    end else if (dot_sel_q[7:4] == 4'h8) begin
      for (int i = 0; i < sstenc_pkg::Digits; i++) begin
        if (dot_sel_q[sstenc_pkg::Digits-1-i]) begin
          fin[i] = fin[i] | sstenc_pkg::DotBit;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      align_q   <= 1'b0;
      scroll_q  <= 8'h00;
      lower_q   <= 1'b0;
      dot_sel_q <= 8'hFF;
      flat_q    <= 8'hFF;
      st_q      <= sstenc_pkg::restart_state(1'b0, 8'h00);
    end else if (cfg_we_i) begin
      case (sstenc_pkg::cfg_reg_e'(cfg_idx_i))
        sstenc_pkg::RegAlignRight: begin
          align_q <= cfg_data_i[0];
          st_q    <= sstenc_pkg::restart_state(cfg_data_i[0], scroll_q);
        end
        sstenc_pkg::RegScrollOffset: begin
          scroll_q <= cfg_data_i;
          st_q     <= sstenc_pkg::restart_state(align_q, cfg_data_i);
        end
        sstenc_pkg::RegLowercase: lower_q   <= cfg_data_i[0];
        sstenc_pkg::RegDotSelect: dot_sel_q <= cfg_data_i;
        sstenc_pkg::RegFlatCode:  flat_q    <= cfg_data_i;
        default: ;
      endcase
    end else if (in_acc) begin
      if (in_ch.terminator) begin
        st_q <= sstenc_pkg::restart_state(align_q, scroll_q);
      end else if (!st_q.stopped) begin
        st_q <= st_step;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc && in_ch.terminator) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && in_ch.terminator) begin
      out_q <= fin;
    end
  end

  assign out_ch.valid       = out_valid_q;
  assign out_ch.digit_zero  = out_q[0];
  assign out_ch.digit_one   = out_q[1];
  assign out_ch.digit_two   = out_q[2];
  assign out_ch.digit_three = out_q[3];

endmodule

/* rtl/sstenc_checker.sv */
// Port-level checks for the seven-segment text encoder, bound to the top level.
// Depends on assert_macros.svh and seven_segment_text_encoder_core.
`include "assert_macros.svh"

module sstenc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        in_term_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] out_digits_i
);

  logic in_acc;
  logic out_stall;

  assign in_acc    = in_valid_i && in_ready_i;
  assign out_stall = out_valid_i && !out_ready_i;

  `ASSERT_NOW(a_result_needs_term, out_valid_i && !$past(out_valid_i), $past(in_acc && in_term_i), "result without terminator")
  `ASSERT_NOW(a_ready_unless_stall, !out_stall, in_ready_i, "input stalled while output free")
  `ASSERT_NEXT(a_no_spurious_result, in_acc && !in_term_i && !out_stall, !out_valid_i, "result from non-terminator")
  `ASSERT_NEXT(a_result_holds, out_stall, out_valid_i && $stable(out_digits_i), "result dropped under stall")

endmodule

bind seven_segment_text_encoder_core sstenc_checker u_sstenc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_ch.valid),
  .in_ready_i   (in_ch.ready),
  .in_term_i    (in_ch.terminator),
  .out_valid_i  (out_ch.valid),
  .out_ready_i  (out_ch.ready),
  .out_digits_i ({out_ch.digit_zero, out_ch.digit_one, out_ch.digit_two, out_ch.digit_three})
);

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// Self-checking testbench for seven_segment_text_encoder_core: streams text bytes,
// predicts the four digit bytes of every terminated text and compares them.
// Depends on sstenc_pkg, sstenc_in_if, sstenc_out_if and the core itself.
module testbench;

  localparam int         CycleLimit   = 1000000;
  localparam int         RandomItems  = 850;
  localparam int         SatDots      = 515;
  localparam int         PosTop       = 511;
  localparam int         PosBottom    = -512;
  localparam logic [7:0] SegDot       = 8'h80;
  localparam logic [7:0] FlatSeg      = 8'h9F;
  localparam logic [7:0] NulChar      = 8'h00;
  localparam logic [3:0] DotMaskTag   = 4'h8;
  localparam logic [2:0] SpareRegLo   = 3'd5;
  localparam logic [2:0] SpareRegHi   = 3'd7;

  localparam logic [7:0] NumSeg [10] = '{
    8'h7E, 8'h30, 8'h6D, 8'h79, 8'h33, 8'h5B, 8'h5F, 8'h70, 8'h7F, 8'h7B};
  localparam logic [7:0] UpSeg [26] = '{
    8'h77, 8'h1F, 8'h4E, 8'h3D, 8'h4F, 8'h47, 8'h5E, 8'h37, 8'h04, 8'h38, 8'h57, 8'h0E,
    8'h55, 8'h15, 8'h1D, 8'h67, 8'h73, 8'h05, 8'h5B, 8'h0F, 8'h3E, 8'h27, 8'h5C, 8'h49,
    8'h3B, 8'h6D};
  localparam logic [7:0] LowSeg [26] = '{
    8'h77, 8'h1F, 8'h0D, 8'h3D, 8'h4F, 8'h47, 8'h5E, 8'h37, 8'h04, 8'h38, 8'h57, 8'h0E,
    8'h55, 8'h15, 8'h1D, 8'h67, 8'h73, 8'h05, 8'h5B, 8'h0F, 8'h3E, 8'h27, 8'h5C, 8'h49,
    8'h3B, 8'h6D};
  localparam logic [7:0] Symbols [6] = '{"-", "_", "'", "!", "^", "#"};

  typedef struct packed {
    logic [7:0] ch;
    logic       term;
  } text_item_t;

  typedef logic [3:0][7:0] digit_row_t;  // index 0 is the leftmost digit

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i;
  logic [2:0] cfg_idx_i;
  logic [7:0] cfg_data_i;

  sstenc_in_if  in_ch ();
  sstenc_out_if out_ch ();

  seven_segment_text_encoder_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

  always #2 clk_i = ~clk_i;

  // Predictor copy of the registers
  logic       right_aligned;
  logic [7:0] scroll_by;
  logic       lower_glyphs;
  logic [7:0] dot_choice;
  logic [7:0] flat_byte;

  // Predictor copy of the text state
  logic [7:0] seg_buf [4];
  int         cursor;
  bit         dot_held;
  logic [7:0] last_seg;
  bit         text_halted;

  text_item_t text_q [$];
  digit_row_t pending_rows [$];
  text_item_t next_item;

  int  send_gap;
  int  stall_left;
  bit  sender_idles;
  bit  receiver_stalls;
  int  faults;
  int  chars_sent;
  int  texts_sent;
  int  rows_checked;
  int  settings_used;
  int  cycles;

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 19);
    if (r < 10) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] seg_of(input logic [7:0] c);
    int k;
    k = 0;
    if (c >= "A" && c <= "Z") begin
      k = c - "A";
      return UpSeg[k];
    end
    if (c >= "a" && c <= "z") begin
      k = c - "a";
      return lower_glyphs ? LowSeg[k] : UpSeg[k];
    end
    if (c >= "0" && c <= "9") begin
      k = c - "0";
      return NumSeg[k];
    end
    case (c)
      "-": return 8'h01;
      "_": return 8'h08;
      "'": return 8'h02;
      "!": return 8'hA0;
      "^": return 8'h62;
      "#": return 8'hA7;
      default: ;
    endcase
    // flat glyph only for bytes that have no glyph of their own
    if (c == flat_byte) return FlatSeg;
    return 8'h00;
  endfunction

  function automatic void put_seg(input int p, input logic [7:0] v);
    if (p >= 0 && p < 4) seg_buf[p] = v;
  endfunction

  function automatic void cursor_up();
    if (cursor < PosTop) cursor++;
  endfunction

  function automatic void cursor_down();
    if (cursor > PosBottom) cursor--;
  endfunction

  function automatic void restart_text();
    for (int i = 0; i < 4; i++) seg_buf[i] = 8'h00;
    cursor      = right_aligned ? 3 : -int'(scroll_by);
    dot_held    = 1'b0;
    last_seg    = 8'h00;
    text_halted = 1'b0;
  endfunction

  function automatic void place_left(input logic [7:0] c, input bit is_dot);
    if (is_dot) begin
      if (cursor != -int'(scroll_by) && !last_seg[7]) begin
        last_seg = last_seg | SegDot;
        put_seg(cursor - 1, last_seg);
      end else begin
        put_seg(cursor, SegDot);
        last_seg = SegDot;
        cursor_up();
      end
    end else if (c == NulChar || cursor >= 4) begin
      text_halted = 1'b1;
    end else begin
      last_seg = seg_of(c);
      put_seg(cursor, last_seg);
      cursor_up();
    end
  endfunction

  function automatic void place_right(input logic [7:0] c, input bit is_dot);
    logic [7:0] g;
    g = 8'h00;
    if (is_dot) begin
      if (dot_held) begin
        put_seg(cursor, SegDot);
        last_seg = SegDot;
        if (cursor == 0) begin
          cursor      = -1;
          text_halted = 1'b1;
        end else begin
          cursor_down();
        end
      end else begin
        dot_held = 1'b1;
      end
    end else if (cursor < 0) begin
      text_halted = 1'b1;
    end else begin
      g = seg_of(c);
      if (dot_held) begin
        // a glyph that already has a dot cannot take the carried one
        if (g[7]) begin
          put_seg(cursor, SegDot);
          cursor--;
        end else begin
          g = g | SegDot;
        end
      end
      if (cursor < 0) begin
        text_halted = 1'b1;
      end else begin
        dot_held = 1'b0;
        put_seg(cursor, g);
        last_seg = g;
        cursor_down();
      end
    end
  endfunction

  function automatic digit_row_t close_text();
    digit_row_t row;
    if (right_aligned) begin
      for (int i = 0; i < 4 && i <= cursor; i++) seg_buf[i] = 8'h00;
    end else begin
      for (int i = (cursor < 0) ? 0 : cursor; i < 4; i++) seg_buf[i] = 8'h00;
    end
    if (dot_choice < 4) begin
      seg_buf[dot_choice] = seg_buf[dot_choice] | SegDot;
    end else if (dot_choice[7:4] == DotMaskTag) begin
      for (int i = 0; i < 4; i++)
        if (dot_choice[3 - i]) seg_buf[i] = seg_buf[i] | SegDot;
    end
    for (int i = 0; i < 4; i++) row[i] = seg_buf[i];
    return row;
  endfunction

  function automatic void encode_item(input text_item_t it);
    bit is_dot;
    is_dot = (it.ch == "." || it.ch == ",");
    if (it.term) begin
      pending_rows.push_back(close_text());
      restart_text();
    end else if (!text_halted) begin
      if (right_aligned) place_right(it.ch, is_dot);
      else place_left(it.ch, is_dot);
    end
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %02h, got %02h", name, want, got);
      faults++;
    end
  endfunction

  // Driver: next transaction from the text queue, with random idle gaps
  always @(posedge clk_i) begin
    if (rst_ni && (!in_ch.valid || in_ch.ready)) begin
      if (send_gap > 0) begin
        in_ch.valid <= 1'b0;
        send_gap--;
      end else if (text_q.size() != 0) begin
        next_item = text_q.pop_front();
        in_ch.valid      <= 1'b1;
        in_ch.character  <= next_item.ch;
        in_ch.terminator <= next_item.term;
        send_gap = sender_idles ? idle_len() : 0;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: predict on accepted input, check on accepted output, drive ready
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready)
        encode_item('{ch: in_ch.character, term: in_ch.terminator});
      if (out_ch.valid && out_ch.ready) begin
        if (pending_rows.size() == 0) begin
          $error("digit row received with no terminated text pending");
          faults++;
        end else begin
          check_field("digit_zero", pending_rows[0][0], out_ch.digit_zero);
          check_field("digit_one", pending_rows[0][1], out_ch.digit_one);
          check_field("digit_two", pending_rows[0][2], out_ch.digit_two);
          check_field("digit_three", pending_rows[0][3], out_ch.digit_three);
          void'(pending_rows.pop_front());
          rows_checked++;
        end
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        if (receiver_stalls && ((out_ch.valid && out_ch.ready) || $urandom_range(0, 15) == 0))
          stall_left = idle_len();
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("seven_segment_text_encoder_core test failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      sstenc_pkg::RegAlignRight: begin
        right_aligned = data[0];
        restart_text();
      end
      sstenc_pkg::RegScrollOffset: begin
        scroll_by = data;
        restart_text();
      end
      sstenc_pkg::RegLowercase: lower_glyphs = data[0];
      sstenc_pkg::RegDotSelect: dot_choice = data;
      sstenc_pkg::RegFlatCode:  flat_byte = data;
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  task automatic add_char(input logic [7:0] c);
    text_q.push_back('{ch: c, term: 1'b0});
    chars_sent++;
  endtask

  task automatic add_string(input string s);
    for (int i = 0; i < s.len(); i++) add_char(s[i]);
  endtask

  task automatic add_end();
    text_q.push_back('{ch: 8'($urandom_range(0, 255)), term: 1'b1});
    texts_sent++;
  endtask

  // Block becomes idle once every queued byte is taken and every row is back
  task automatic drain();
    while (text_q.size() != 0 || in_ch.valid || pending_rows.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 22) return 8'("A" + $urandom_range(0, 25));
    if (r < 38) return 8'("a" + $urandom_range(0, 25));
    if (r < 52) return 8'("0" + $urandom_range(0, 9));
    if (r < 68) return $urandom_range(0, 1) ? "." : ",";
    if (r < 80) return Symbols[$urandom_range(0, 5)];
    if (r < 86) return flat_byte;
    if (r < 89) return NulChar;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic random_settings();
    int r;
    if ($urandom_range(0, 1)) begin
      write_reg(sstenc_pkg::RegAlignRight, 8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 2) == 0) begin
      r = $urandom_range(0, 9);
      if (r < 4) write_reg(sstenc_pkg::RegScrollOffset, 8'h00);
      else if (r < 8) write_reg(sstenc_pkg::RegScrollOffset, 8'($urandom_range(1, 5)));
      else if (r == 8) write_reg(sstenc_pkg::RegScrollOffset, 8'hFF);
      else write_reg(sstenc_pkg::RegScrollOffset, 8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 2) == 0) begin
      write_reg(sstenc_pkg::RegLowercase, 8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 1)) begin
      r = $urandom_range(0, 9);
      if (r < 4) begin
        write_reg(sstenc_pkg::RegDotSelect, 8'($urandom_range(0, 3)));
      end else if (r < 7) begin
        write_reg(sstenc_pkg::RegDotSelect, {DotMaskTag, 4'($urandom_range(0, 15))});
      end else if (r == 7) begin
        write_reg(sstenc_pkg::RegDotSelect, 8'hFF);
      end else begin
        write_reg(sstenc_pkg::RegDotSelect, 8'($urandom_range(0, 255)));
      end
    end
    if ($urandom_range(0, 2) == 0) begin
      r = $urandom_range(0, 9);
      if (r < 2) write_reg(sstenc_pkg::RegFlatCode, pick_char());
      else if (r == 2) write_reg(sstenc_pkg::RegFlatCode, NulChar);
      else write_reg(sstenc_pkg::RegFlatCode, 8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 7) == 0)
      write_reg(3'($urandom_range(SpareRegLo, SpareRegHi)), 8'($urandom_range(0, 255)));
    end_writes();
  endtask

  initial begin
    int random_base;
    int len;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = sstenc_pkg::RegAlignRight;
    cfg_data_i       = 8'h00;
    in_ch.valid      = 1'b0;
    in_ch.character  = 8'h00;
    in_ch.terminator = 1'b0;
    out_ch.ready     = 1'b0;
    send_gap         = 0;
    stall_left       = 0;
    sender_idles     = 1'b1;
    receiver_stalls  = 1'b1;
    faults           = 0;
    chars_sent       = 0;
    texts_sent       = 0;
    rows_checked     = 0;
    settings_used    = 1;
    cycles           = 0;
    right_aligned    = 1'b0;
    scroll_by        = 8'h00;
    lower_glyphs     = 1'b0;
    dot_choice       = 8'hFF;
    flat_byte        = 8'hFF;
    restart_text();

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: letters, digits, dot folding, overflow, zero byte, empty text
    add_string("Az09");
    add_end();
    add_string(".-..#,");
    add_end();
    add_string("12345");
    add_end();
    add_char("H");
    add_char(NulChar);
    add_char("I");
    add_end();
    add_end();
    drain();

    // Right aligned, lowercase glyphs, dot mask, flat glyph on '@'
    write_reg(sstenc_pkg::RegAlignRight, 8'h01);
    write_reg(sstenc_pkg::RegLowercase, 8'h01);
    write_reg(sstenc_pkg::RegDotSelect, {DotMaskTag, 4'hA});
    write_reg(sstenc_pkg::RegFlatCode, "@");
    end_writes();
    add_string("c.!@.,");
    add_end();
    add_string("12345");
    add_end();
    add_string("8.");
    add_end();
    drain();

    // Left aligned with scroll: leading characters land off the digits
    write_reg(sstenc_pkg::RegAlignRight, 8'h00);
    write_reg(sstenc_pkg::RegScrollOffset, 8'h02);
    write_reg(sstenc_pkg::RegLowercase, 8'h00);
    write_reg(sstenc_pkg::RegDotSelect, 8'h03);
    end_writes();
    add_string("A.BCDEF");
    add_end();
    drain();

    // Largest scroll, flat glyph on the zero byte
    write_reg(sstenc_pkg::RegScrollOffset, 8'hFF);
    write_reg(sstenc_pkg::RegFlatCode, NulChar);
    write_reg(sstenc_pkg::RegDotSelect, 8'h00);
    end_writes();
    add_string("A");
    add_end();
    drain();
    write_reg(sstenc_pkg::RegAlignRight, 8'h01);
    write_reg(sstenc_pkg::RegDotSelect, {DotMaskTag, 4'hF});
    end_writes();
    add_char(NulChar);
    add_string("B");
    add_end();
    drain();

    // Long run of dots drives the position into saturation
    write_reg(sstenc_pkg::RegAlignRight, 8'h00);
    write_reg(sstenc_pkg::RegScrollOffset, 8'h00);
    write_reg(sstenc_pkg::RegDotSelect, 8'hFF);
    write_reg(sstenc_pkg::RegFlatCode, 8'hFF);
    end_writes();
    add_char("8");
    repeat (SatDots) add_char(".");
    add_end();
    drain();

    random_base = chars_sent + texts_sent;
    while (chars_sent + texts_sent - random_base < RandomItems) begin
      random_settings();
      sender_idles    = ($urandom_range(0, 3) != 0);
      receiver_stalls = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(4, 10)) begin
        len = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 6) : $urandom_range(7, 12);
        repeat (len) add_char(pick_char());
        add_end();
      end
      drain();
    end
    repeat (10) @(posedge clk_i);

    $display("Covered %0d characters in %0d texts over %0d register settings,",
             chars_sent, texts_sent, settings_used);
    $display("both alignments, scrolling, dot folding and overflow; %0d rows compared.",
             rows_checked);
    if (faults == 0 && pending_rows.size() == 0) begin
      $display("seven_segment_text_encoder_core test passed");
    end else begin
      $display("seven_segment_text_encoder_core test failed");
    end
    $finish;
  end

endmodule
